[hw/rtl/btc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btc_pkg
// Shared codes, character constants and helpers for the bracket token checker.
// ----------------------------------------------------------------------------
package btc_pkg;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_FRAMING = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  // content buffer sizing
  localparam int unsigned CONTENT_DEPTH = 5;
  localparam int unsigned COUNT_W       = 3;
  localparam logic [COUNT_W-1:0] COUNT_DEPTH = COUNT_W'(CONTENT_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_SAT   = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] COUNT_ONE   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_WORD3 = COUNT_W'(3);

  // framing characters
  localparam logic [7:0] CHAR_OPEN  = "<";
  localparam logic [7:0] CHAR_CLOSE = ">";

  // keyword patterns, lower case
  localparam logic [23:0] WORD_LOG   = "log";
  localparam logic [23:0] WORD_SEN   = "sen";
  localparam logic [23:0] WORD_COS   = "cos";
  localparam logic [39:0] WORD_ENTER = "enter";

  // upper case letters map to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // characters that form a valid one-character token
  function automatic logic is_single_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "E" || c == "e" || c == "." ||
           c == "+" || c == "-" || c == "*" || c == "/" || c == "^" ||
           c == "(" || c == ")";
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bracket_token_checker_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_token_checker_top
// The verdict beat is registered and valid in the cycle after the beat marked last.
// Throughput: one character per cycle while in_ready is high; state updates in a single pass.
// The output register frees in the cycle it is taken, so input keeps flowing.
// Reset: synchronous rst clears token state, error and output valid.
// ----------------------------------------------------------------------------
module bracket_token_checker_top
  import btc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       is_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      verdict
);

  // token state
  logic               inside_token, inside_token_next;
  logic [COUNT_W-1:0] content_count, content_count_next;
  logic [7:0]         content_chars [CONTENT_DEPTH];
  verdict_t           first_error, first_error_next;
  verdict_t           verdict_reg, verdict_now;
  logic               store_en;
  logic               content_ok;
  logic               in_beat;
  logic [7:0]         f0, f1, f2, f3, f4;

  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;
  assign verdict  = verdict_reg;

  // content check on the buffered characters
  always_comb begin
    f0 = fold_case(content_chars[0]);
    f1 = fold_case(content_chars[1]);
    f2 = fold_case(content_chars[2]);
    f3 = fold_case(content_chars[3]);
    f4 = fold_case(content_chars[4]);
    content_ok = 1'b0;
    if (content_count == COUNT_ONE) begin
      content_ok = is_single_ok(content_chars[0]);
    end else if (content_count == COUNT_WORD3) begin
      content_ok = ({f0, f1, f2} == WORD_LOG) || ({f0, f1, f2} == WORD_SEN) ||
                   ({f0, f1, f2} == WORD_COS);
    end else if (content_count == COUNT_DEPTH) begin
      content_ok = ({f0, f1, f2, f3, f4} == WORD_ENTER);
    end
  end

  // next state for one character
  always_comb begin
    inside_token_next  = inside_token;
    content_count_next = content_count;
    first_error_next   = first_error;
    store_en           = 1'b0;
    if (first_error == VERDICT_OK) begin
      if (!inside_token) begin
        if (char_code == CHAR_OPEN) begin
          inside_token_next  = 1'b1;
          content_count_next = '0;
        end else begin
          first_error_next = VERDICT_FRAMING;
        end
      end else if (char_code == CHAR_CLOSE) begin
        inside_token_next  = 1'b0;
        content_count_next = '0;
        if (!content_ok) begin
          first_error_next = VERDICT_INVALID;
        end
      end else begin
        store_en = (content_count < COUNT_DEPTH);
        if (content_count < COUNT_SAT) begin
          content_count_next = content_count + COUNT_ONE;
        end
      end
    end
    // an open token at the end is a framing error
    verdict_now = first_error_next;
    if (first_error_next == VERDICT_OK && inside_token_next) begin
      verdict_now = VERDICT_FRAMING;
    end
  end

  // control state, restarts after every verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_token  <= 1'b0;
      content_count <= '0;
      first_error   <= VERDICT_OK;
    end else if (in_beat) begin
      if (is_last) begin
        inside_token  <= 1'b0;
        content_count <= '0;
        first_error   <= VERDICT_OK;
      end else begin
        inside_token  <= inside_token_next;
        content_count <= content_count_next;
        first_error   <= first_error_next;
      end
    end
  end

  // content buffer, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat && store_en) begin
      content_chars[content_count] <= char_code;
    end
  end

  // verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat && is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && is_last) begin
      verdict_reg <= verdict_now;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/btc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btc_checker
// Port-level checks on the bracket token checker, bound to the top level.
// ----------------------------------------------------------------------------
module btc_checker
  import btc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       is_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] verdict
);

  // a stalled verdict beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict beat changed while stalled");

  // a last character always yields a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last |=> out_valid)
    else $error("no verdict after last character");

  // a new verdict only follows a last character
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && is_last))
    else $error("verdict without last character");

  // verdict code stays within the defined codes
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_OK || verdict == VERDICT_FRAMING ||
                   verdict == VERDICT_INVALID))
    else $error("undefined verdict code");

  // an empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind bracket_token_checker_top btc_checker u_btc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .is_last   (is_last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .verdict   (verdict)
);
`default_nettype wire
